### design/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package rau_pkg;
    localparam int unsigned Width = 32;
    localparam int unsigned PWidth = 2 * Width;
    localparam int unsigned CntW = $clog2(PWidth + 1);

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_CMP = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    // result word, fields from the highest bit down
    typedef struct packed {
        logic [1:0]  status;
        logic        is_equal;
        logic        is_less;
        logic [30:0] res_den;
        logic [31:0] res_num;
    } t_res;

    // gcd unit control and status
    typedef struct packed {
        logic start;
    } t_gcd_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gcd_sts;
endpackage

### design/rau_gcd.sv
// rau_gcd: binary gcd and exact quotient of two 64-bit magnitudes
// depends on rau_pkg; one shift or subtract step per cycle, restoring divide after
`timescale 1ns / 1ps
module rau_gcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rau_pkg::t_gcd_ctl           i_ctl,
    input  logic [rau_pkg::PWidth-1:0]  i_x,
    input  logic [rau_pkg::PWidth-1:0]  i_y,
    output rau_pkg::t_gcd_sts           o_sts,
    output logic [rau_pkg::PWidth-1:0]  o_qx,
    output logic [rau_pkg::PWidth-1:0]  o_qy
);
    import rau_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_STEP, S_DIVX, S_DIVY, S_DONE} t_state;

    t_state r_state, n_state;
    logic [PWidth-1:0] r_u, n_u, r_v, n_v;
    logic [PWidth-1:0] r_x, n_x, r_y, n_y;
    logic [PWidth-1:0] r_q, n_q, r_rem, n_rem, r_qx, n_qx;
    logic [CntW-1:0]   r_k, n_k, r_cnt, n_cnt;
    logic [PWidth-1:0] r_g, n_g;
    logic [PWidth-1:0] w_sh_rem, w_dividend;
    logic [PWidth:0]   w_diff;

    // restoring divide datapath: one quotient bit per cycle
    always_comb begin
        w_dividend = (r_state == S_DIVX) ? r_x : r_y;
        w_sh_rem   = {r_rem[PWidth-2:0], w_dividend[r_cnt[CntW-2:0]]};
        w_diff     = {1'b0, w_sh_rem} - {1'b0, r_g};
    end

    always_comb begin
        n_state = r_state; n_u = r_u; n_v = r_v; n_x = r_x; n_y = r_y;
        n_q = r_q; n_rem = r_rem; n_qx = r_qx; n_k = r_k; n_cnt = r_cnt; n_g = r_g;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_u = i_x; n_v = i_y; n_x = i_x; n_y = i_y;
                    n_k = '0; n_state = S_SHIFT;
                end
            end
            // strip common factors of two
            S_SHIFT: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1; n_v = r_v >> 1; n_k = r_k + 1'b1;
                end else begin
                    n_state = S_STEP;
                end
            end
            // one shift or subtract a cycle
            S_STEP: begin
                if (r_v == '0) begin
                    n_g = r_u << r_k;
                    n_cnt = CntW'(PWidth - 1);
                    n_rem = '0; n_q = '0;
                    n_state = S_DIVX;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u > r_v) begin
                    n_u = r_v; n_v = r_u - r_v;
                end else begin
                    n_v = r_v - r_u;
                end
            end
            S_DIVX, S_DIVY: begin
                if (!w_diff[PWidth]) begin
                    n_rem = w_diff[PWidth-1:0];
                    n_q = {r_q[PWidth-2:0], 1'b1};
                end else begin
                    n_rem = w_sh_rem;
                    n_q = {r_q[PWidth-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    if (r_state == S_DIVX) begin
                        n_qx = n_q; n_q = '0; n_rem = '0;
                        n_cnt = CntW'(PWidth - 1);
                        n_state = S_DIVY;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_u <= n_u; r_v <= n_v; r_x <= n_x; r_y <= n_y;
        r_q <= n_q; r_rem <= n_rem; r_qx <= n_qx;
        r_k <= n_k; r_cnt <= n_cnt; r_g <= n_g;
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = (r_state == S_DONE);
    assign o_qx = r_qx;
    assign o_qy = r_q;
endmodule

### design/rational_arith_unit.sv
// rational_arith_unit: exact add, subtract, multiply, divide and compare of fractions
// depends on rau_pkg and rau_gcd
`timescale 1ns / 1ps
//  channel | dir | fields (low bit first)
//  s_axis  | in  | func, a_num, a_den, b_num, b_den
//  m_axis  | out | res_num, res_den, is_less, is_equal, status
//
// an item uses up to three 32x32 products on one shared multiplier, a binary
// gcd of shift or subtract steps, then two 64-step divides. an error result is
// set in S_MUL0 and a compare result in S_COMB, each then shown in S_OUT. one
// item is in flight; s_axis_tready is low until the result is taken. reset
// clears all control.
module rational_arith_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // func[2:0], a_num, a_den, b_num, b_den, 5'b0
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // res_num, res_den, is_less, is_equal, status, 5'b0
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_GCD, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0] r_func;
    logic signed [Width-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PWidth-1:0] r_p0, r_p1, r_n, r_d;
    logic r_neg;
    t_res r_res;
    t_gcd_ctl w_ctl;
    t_gcd_sts w_sts;
    logic [PWidth-1:0] w_qx, w_qy, w_nm, w_dm;
    logic signed [Width-1:0] w_ma, w_mb;
    logic signed [PWidth-1:0] w_prod;
    logic [PWidth-1:0] w_lim;
    logic w_bad;

    // shared multiplier operand select
    always_comb begin
        w_ma = r_an; w_mb = r_bd;
        unique case (r_state)
            S_MUL0: begin
                w_ma = r_an;
                w_mb = (r_func == FN_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                w_ma = r_ad;
                w_mb = (r_func == FN_MUL || r_func == FN_DIV) ? r_bd : r_bn;
                if (r_func == FN_DIV) w_mb = r_bn;
                if (r_func == FN_MUL) w_mb = r_bd;
            end
            // common denominator for add and subtract
            S_MUL2: begin
                w_ma = r_ad; w_mb = r_bd;
            end
            default: begin
                w_ma = r_an; w_mb = r_bd;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    assign w_bad = (r_ad <= 0) || (r_bd <= 0) || (r_func > FN_CMP)
                   || (r_func == FN_DIV && r_bn == 0);
    assign w_nm = r_n[PWidth-1] ? (~r_n + 1'b1) : r_n;
    assign w_dm = r_d[PWidth-1] ? (~r_d + 1'b1) : r_d;
    assign w_lim = {{(PWidth-Width+1){1'b0}}, {(Width-1){1'b1}}};
    // a zero numerator skips the gcd
    assign w_ctl.start = (r_state == S_GCD) && !w_sts.busy && !r_p0[0] && (r_n != '0);

    rau_gcd u_gcd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_x(w_nm), .i_y(w_dm), .o_sts(w_sts), .o_qx(w_qx), .o_qy(w_qy)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_func <= s_axis_tdata[2:0];
                    r_an <= s_axis_tdata[34:3];
                    r_ad <= s_axis_tdata[66:35];
                    r_bn <= s_axis_tdata[98:67];
                    r_bd <= s_axis_tdata[130:99];
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_res <= '0;
                    if (w_bad) begin
                        r_res.status <= ST_BAD;
                        r_state <= S_OUT;
                    end else begin
                        r_p0 <= w_prod;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1 <= w_prod;
                    r_state <= (r_func == FN_ADD || r_func == FN_SUB) ? S_MUL2 : S_COMB;
                end
                S_MUL2: begin
                    r_d <= w_prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_func == FN_CMP) begin
                        r_res.is_less <= r_p0 < r_p1;
                        r_res.is_equal <= r_p0 == r_p1;
                        r_state <= S_OUT;
                    end else begin
                        unique case (r_func)
                            FN_ADD: begin r_n <= r_p0 + r_p1; end
                            FN_SUB: begin r_n <= r_p0 - r_p1; end
                            default: begin r_n <= r_p0; end
                        endcase
                        if (r_func != FN_ADD && r_func != FN_SUB) begin
                            r_d <= r_p1;
                        end
                        r_p0 <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (!r_p0[0]) begin
                        r_neg <= r_n[PWidth-1] ^ r_d[PWidth-1];
                        if (r_n == 0) begin
                            r_res.res_den <= 31'd1;
                            r_state <= S_OUT;
                        end
                        r_p0 <= 64'd1;
                    end else if (w_sts.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_qy > w_lim || w_qx > (r_neg ? w_lim + 1'b1 : w_lim)) begin
                        r_res.status <= ST_OVF;
                    end else begin
                        r_res.res_num <= r_neg ? Width'(~w_qx + 1'b1) : w_qx[Width-1:0];
                        r_res.res_den <= w_qy[30:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {5'b0, r_res};
endmodule

### sim/rational_arith_unit_test.sv
// rational_arith_unit_test: self-checking bench for the fraction arithmetic unit
// drives table-driven and random words on s_axis, checks m_axis against a local predictor
// depends on rau_pkg and the rational_arith_unit design
`timescale 1ns / 1ps
module rational_arith_unit_test;
    import rau_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_op;

    typedef struct {
        t_op  op;
        bit   known;
        t_res res;
    } t_row;

    rational_arith_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_res expected_q[$];
    int   err_cnt = 0;
    int   sent_cnt = 0;
    int   got_cnt = 0;
    int   bad_cnt = 0;
    int   ovf_cnt = 0;
    int   rx_idle = 0;
    bit   calm = 1'b0;
    bit   hold_rx = 1'b0;

    function automatic longint unsigned mag(longint x);
        return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_res make_res(logic [31:0] n, logic [30:0] d, bit lt, bit eq,
                                      t_status st);
        t_res r;
        r.res_num = n;
        r.res_den = d;
        r.is_less = lt;
        r.is_equal = eq;
        r.status = st;
        return r;
    endfunction

    // exact fraction result with reduction and range check
    function automatic t_res reduce_fraction(t_op op);
        longint an, ad, bn, bd, n, d;
        longint unsigned nm, dm, g, lim;
        bit neg;
        an = longint'($signed(op.a_num));
        ad = longint'($signed(op.a_den));
        bn = longint'($signed(op.b_num));
        bd = longint'($signed(op.b_den));
        if (ad <= 0 || bd <= 0 || op.func > FN_CMP) return make_res(0, 0, 0, 0, ST_BAD);
        case (op.func)
            FN_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            FN_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            FN_MUL: begin n = an * bn; d = ad * bd; end
            FN_DIV: begin
                if (bn == 0) return make_res(0, 0, 0, 0, ST_BAD);
                n = an * bd; d = ad * bn;
            end
            default: begin
                n = an * bd;
                d = ad * bn;
                return make_res(0, 0, n < d, n == d, ST_OK);
            end
        endcase
        if (n == 0) return make_res(0, 1, 0, 0, ST_OK);
        neg = (n < 0) != (d < 0);
        nm = mag(n);
        dm = mag(d);
        g = gcd_of(nm, dm);
        nm = nm / g;
        dm = dm / g;
        lim = 64'h7FFF_FFFF;
        if (dm > lim || nm > (neg ? lim + 1 : lim)) return make_res(0, 0, 0, 0, ST_OVF);
        return make_res(neg ? 32'(64'd0 - nm) : 32'(nm), 31'(dm), 0, 0, ST_OK);
    endfunction

    function automatic logic [135:0] pack_op(t_op op);
        return {5'b0, op.b_den, op.b_num, op.a_den, op.a_num, op.func};
    endfunction

    function automatic t_op mk(logic [2:0] f, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
        t_op o;
        o.func = f; o.a_num = an; o.a_den = ad; o.b_num = bn; o.b_den = bd;
        return o;
    endfunction

    // random operand, leaning toward small magnitudes and extremes
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($urandom_range(0, 65535)) - 32'd32768;
            4: return $urandom & 32'h0000_0FFF;
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rnd_den();
        case ($urandom_range(0, 9))
            0: return rnd_word();
            1: return 32'h7FFF_FFFF;
            2: return 32'd1;
            3: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    task automatic send_word(t_op op);
        s_axis_tdata  <= pack_op(op);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(reduce_fraction(op));
        sent_cnt++;
    endtask

    task automatic idle_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // receiver: random idle bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_rx) begin
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (rx_idle > 0) begin
            rx_idle--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_idle = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[66:0]);
            got_cnt++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got.status == ST_BAD) bad_cnt++;
                if (got.status == ST_OVF) ovf_cnt++;
                if (got.res_num !== want.res_num)
                    $display("%0t res_num exp %h got %h", $time, want.res_num, got.res_num);
                if (got.res_den !== want.res_den)
                    $display("%0t res_den exp %h got %h", $time, want.res_den, got.res_den);
                if (got.is_less !== want.is_less)
                    $display("%0t is_less exp %b got %b", $time, want.is_less, got.is_less);
                if (got.is_equal !== want.is_equal)
                    $display("%0t is_equal exp %b got %b", $time, want.is_equal, got.is_equal);
                if (got.status !== want.status)
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                if (got !== want) err_cnt++;
            end
        end
    end

    // run limit
    initial begin
        #60ms;
        $display("rational_arith_unit_test: errors");
        $finish;
    end

    t_row dir_tbl[$];

    initial begin
        t_op op;
        int  k, hold_n;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; known rows carry a hand-read result
        dir_tbl.push_back('{mk(FN_ADD, 0, 1, 0, 1), 1, make_res(0, 1, 0, 0, ST_OK)});
        dir_tbl.push_back('{mk(FN_ADD, 1, 0, 1, 1), 1, make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(FN_SUB, 1, 1, 1, 32'hFFFF_FFFF), 1,
                            make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(FN_CMP, 1, 32'h8000_0000, 1, 1), 1,
                            make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(FN_DIV, 5, 3, 0, 7), 1, make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(3'd5, 1, 1, 1, 1), 1, make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(3'd6, 1, 1, 1, 1), 1, make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(3'd7, 1, 1, 1, 1), 1, make_res(0, 0, 0, 0, ST_BAD)});
        dir_tbl.push_back('{mk(FN_ADD, 32'h7FFF_FFFF, 1, 1, 1), 1,
                            make_res(0, 0, 0, 0, ST_OVF)});
        dir_tbl.push_back('{mk(FN_SUB, 32'h8000_0000, 1, 1, 1), 1,
                            make_res(0, 0, 0, 0, ST_OVF)});
        dir_tbl.push_back('{mk(FN_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1), 1,
                            make_res(0, 0, 0, 0, ST_OVF)});
        dir_tbl.push_back('{mk(FN_MUL, 32'h8000_0000, 1, 1, 1), 1,
                            make_res(32'h8000_0000, 1, 0, 0, ST_OK)});
        dir_tbl.push_back('{mk(FN_DIV, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF), 1,
                            make_res(1, 1, 0, 0, ST_OK)});
        dir_tbl.push_back('{mk(FN_CMP, 1, 2, 2, 4), 1, make_res(0, 0, 0, 1, ST_OK)});
        dir_tbl.push_back('{mk(FN_CMP, 32'hFFFF_FFFF, 3, 0, 1), 1,
                            make_res(0, 0, 1, 0, ST_OK)});
        dir_tbl.push_back('{mk(FN_ADD, 1, 2, 1, 3), 0, '0});
        dir_tbl.push_back('{mk(FN_SUB, 1, 2, 3, 4), 0, '0});
        dir_tbl.push_back('{mk(FN_MUL, 32'hFFFF_FFFA, 4, 10, 9), 0, '0});
        dir_tbl.push_back('{mk(FN_DIV, 7, 32'h7FFF_FFFF, 32'hFFFF_FFFD, 32'h7FFF_FFFE), 0, '0});
        dir_tbl.push_back('{mk(FN_DIV, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1), 0, '0});
        dir_tbl.push_back('{mk(FN_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1), 0, '0});
        dir_tbl.push_back('{mk(FN_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFE), 0, '0});

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].known && reduce_fraction(dir_tbl[i].op) !== dir_tbl[i].res) begin
                $display("%0t table row %0d exp %h got %h", $time, i, dir_tbl[i].res,
                         reduce_fraction(dir_tbl[i].op));
                err_cnt++;
            end
            send_word(dir_tbl[i].op);
            idle_gap();
        end

        // random words; a long receiver hold-off in the middle
        for (k = 0; k < 1330; k++) begin
            if (k == 400) begin
                hold_rx = 1'b1;
                fork
                    begin
                        hold_n = 0;
                        while (hold_n < 600) begin
                            @(posedge i_clk);
                            hold_n++;
                        end
                        hold_rx = 1'b0;
                    end
                join_none
            end
            if (k == 800) begin
                // sender pause until all results are back
                s_axis_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
            if (k == 1200) calm = 1'b1;
            op.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            op.a_num = rnd_word();
            op.b_num = ($urandom_range(0, 15) == 0) ? 32'd0 : rnd_word();
            op.a_den = rnd_den();
            op.b_den = rnd_den();
            send_word(op);
            idle_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d words sent, %0d results, %0d bad-input and %0d overflow cases",
                 sent_cnt, got_cnt, bad_cnt, ovf_cnt);
        if (err_cnt == 0)
            $display("rational_arith_unit_test: clean");
        else
            $display("rational_arith_unit_test: errors");
        $finish;
    end
endmodule
